// File: hdl/bpte_pkg.sv
// ----------------------------------------------------------------------------
// bpte_pkg
// shared constants, codes and control/status types of the token expander
// ----------------------------------------------------------------------------
package bpte_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int STACK_DEPTH   = 32;
  localparam int MAX_RUN       = 64;

  localparam int SYM_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int PAIR_W     = 2 * SYM_W;
  localparam int LEAF_LIMIT = 256;

  localparam int TBL_AW = $clog2(TABLE_ENTRIES);
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int BUF_AW = $clog2(MAX_RUN);
  localparam int CNT_W  = $clog2(MAX_RUN + 1);

  localparam logic [SYM_W-1:0] LAST_SYMBOL_RST = SYM_W'(LEAF_LIMIT - 1);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;
  localparam logic [1:0] ERR_RUN_LONG = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       push;
    logic       pop;
    logic       leaf_wr;
    logic       rd_clear;
    logic       rd_inc;
    logic       load_byte;
    logic       load_err;
    logic [1:0] err_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dec_go;
    logic tok_bad;
    logic cur_low;
    logic pair_leaf;
    logic stack_full;
    logic stack_empty;
    logic run_full;
    logic rd_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: hdl/bpte_in_if.sv
// ----------------------------------------------------------------------------
// bpte_in_if
// input channel: table write or token decode transactions
// ----------------------------------------------------------------------------
interface bpte_in_if;
  import bpte_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SYM_W-1:0] symbol;
  logic [SYM_W-1:0] left_part;
  logic [SYM_W-1:0] right_part;
  logic             final_token;

  modport source (
    output valid, cmd, symbol, left_part, right_part, final_token,
    input  ready
  );

  modport sink (
    input  valid, cmd, symbol, left_part, right_part, final_token,
    output ready
  );

endinterface

// File: hdl/bpte_out_if.sv
// ----------------------------------------------------------------------------
// bpte_out_if
// result channel: one decoded byte or one error per transaction
// ----------------------------------------------------------------------------
interface bpte_out_if;
  import bpte_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              text_end;
  logic [1:0]        error_code;

  modport source (
    output valid, out_byte, run_last, text_end, error_code,
    input  ready
  );

  modport sink (
    input  valid, out_byte, run_last, text_end, error_code,
    output ready
  );

endinterface

// File: hdl/bpte_ram.sv
// ----------------------------------------------------------------------------
// bpte_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bpte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bpte_ctrl.sv
// ----------------------------------------------------------------------------
// bpte_ctrl
// sequencer for table writes, depth first walk and run readout
// ----------------------------------------------------------------------------
module bpte_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpte_pkg::dp_stat_t    st,
  output bpte_pkg::ctrl_cmd_t   cmd
);
  import bpte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LOOKUP,
    S_POP,
    S_FETCH,
    S_LOAD,
    S_ERROR
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] err_code_r, err_code_nxt;
  logic       leaf_hit;

  always_comb begin
    state_nxt    = state_r;
    err_code_nxt = err_code_r;
    leaf_hit     = 1'b0;
    cmd          = '0;
    cmd.err_code = err_code_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = 1'b1;
        if (st.dec_go) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.tok_bad) begin
          err_code_nxt = ERR_UNKNOWN;
          state_nxt    = S_ERROR;
        end else if (st.cur_low) begin
          leaf_hit = 1'b1;
        end else begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (st.pair_leaf) begin
          leaf_hit = 1'b1;
        end else if (st.stack_full) begin
          err_code_nxt = ERR_OVERFLOW;
          state_nxt    = S_ERROR;
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_FETCH: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!st.out_busy) begin
          cmd.load_byte = 1'b1;
          if (st.rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_inc = 1'b1;
            state_nxt  = S_FETCH;
          end
        end
      end
      S_ERROR: begin
        if (!st.out_busy) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // leaf found in check or lookup
    if (leaf_hit) begin
      if (st.run_full) begin
        err_code_nxt = ERR_RUN_LONG;
        state_nxt    = S_ERROR;
      end else begin
        cmd.leaf_wr = 1'b1;
        if (st.stack_empty) begin
          cmd.rd_clear = 1'b1;
          state_nxt    = S_FETCH;
        end else begin
          state_nxt = S_POP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      err_code_r <= ERR_OK;
    end else begin
      state_r    <= state_nxt;
      err_code_r <= err_code_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_byte || cmd.load_err) |-> !st.out_busy)
    else $error("result register loaded while a transaction is pending");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !st.stack_full)
    else $error("push with no room on the walk stack");

  a_run_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.leaf_wr |-> !st.run_full)
    else $error("byte written past the run limit");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !st.stack_empty)
    else $error("pop from an empty walk stack");

  a_walk_after_go: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && st.dec_go) |=> (state_r == S_CHECK))
    else $error("decode transaction did not start a walk");

endmodule

// File: hdl/bpte_dp.sv
// ----------------------------------------------------------------------------
// bpte_dp
// merge table, walk stack, run buffer, config register and result register
// ----------------------------------------------------------------------------
module bpte_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bpte_pkg::ctrl_cmd_t       cmd,
  output bpte_pkg::dp_stat_t        st,
  bpte_in_if.sink                   in_ch,
  bpte_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [bpte_pkg::SYM_W-1:0] cfg_data
);
  import bpte_pkg::*;

  logic [SYM_W-1:0]  last_symbol_r;
  logic [SYM_W-1:0]  limit;
  logic [SYM_W-1:0]  cur_r;
  logic              final_r;
  logic [SP_W-1:0]   sp_r;
  logic [CNT_W-1:0]  count_r;
  logic [BUF_AW-1:0] rd_idx_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              run_last_r;
  logic              text_end_r;
  logic [1:0]        err_r;

  logic              in_fire;
  logic              start;
  logic              tbl_we;
  logic [PAIR_W-1:0] tbl_rdata;
  logic [SYM_W-1:0]  pair_l;
  logic [SYM_W-1:0]  pair_r;
  logic [SYM_W-1:0]  stk_rdata;
  logic [SP_W-1:0]   sp_dec;
  logic [BYTE_W-1:0] leaf_byte;
  logic [BYTE_W-1:0] buf_rdata;

  assign in_fire = cmd.accept && in_ch.valid;
  assign start   = in_fire && (in_ch.cmd == CMD_DECODE);
  assign tbl_we  = in_fire && (in_ch.cmd == CMD_WRITE) &&
                   (32'(in_ch.symbol) >= LEAF_LIMIT) &&
                   (32'(in_ch.symbol) < TABLE_ENTRIES);
  assign in_ch.ready = cmd.accept;

  assign limit     = (last_symbol_r < LAST_SYMBOL_RST) ? LAST_SYMBOL_RST : last_symbol_r;
  assign pair_l    = tbl_rdata[PAIR_W-1:SYM_W];
  assign pair_r    = tbl_rdata[SYM_W-1:0];
  assign sp_dec    = sp_r - SP_W'(1);
  assign leaf_byte = st.cur_low ? cur_r[BYTE_W-1:0] : pair_l[BYTE_W-1:0];

  bpte_ram #(.WIDTH(PAIR_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(in_ch.symbol)),
    .wdata ({in_ch.left_part, in_ch.right_part}),
    .raddr (TBL_AW'(cur_r)),
    .rdata (tbl_rdata)
  );

  bpte_ram #(.WIDTH(SYM_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp_r[STK_AW-1:0]),
    .wdata (pair_r),
    .raddr (sp_dec[STK_AW-1:0]),
    .rdata (stk_rdata)
  );

  bpte_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_RUN)) u_run_buf (
    .clk   (clk),
    .we    (cmd.leaf_wr),
    .waddr (count_r[BUF_AW-1:0]),
    .wdata (leaf_byte),
    .raddr (rd_idx_r),
    .rdata (buf_rdata)
  );

  always_comb begin
    st             = '0;
    st.dec_go      = in_ch.valid && (in_ch.cmd == CMD_DECODE);
    st.tok_bad     = (cur_r > limit) || (32'(cur_r) >= TABLE_ENTRIES);
    st.cur_low     = 32'(cur_r) < LEAF_LIMIT;
    st.pair_leaf   = (pair_l == cur_r);
    st.stack_full  = sp_r > SP_W'(STACK_DEPTH - 2);
    st.stack_empty = (sp_r == '0);
    st.run_full    = count_r >= CNT_W'(MAX_RUN);
    st.rd_last     = (CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r;
    st.out_busy    = out_valid_r && !out_ch.ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_symbol_r <= LAST_SYMBOL_RST;
      sp_r          <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        last_symbol_r <= cfg_data;
      end
      if (start) begin
        sp_r <= '0;
      end else if (cmd.push) begin
        sp_r <= sp_r + SP_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_dec;
      end
      if (start) begin
        count_r <= '0;
      end else if (cmd.leaf_wr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.load_byte || cmd.load_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r   <= in_ch.symbol;
      final_r <= in_ch.final_token;
    end else if (cmd.push) begin
      cur_r <= pair_l;
    end else if (cmd.pop) begin
      cur_r <= stk_rdata;
    end
    if (cmd.rd_clear) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx_r <= rd_idx_r + BUF_AW'(1);
    end
    if (cmd.load_byte) begin
      out_byte_r <= buf_rdata;
      run_last_r <= st.rd_last;
      text_end_r <= st.rd_last && final_r;
      err_r      <= ERR_OK;
    end else if (cmd.load_err) begin
      out_byte_r <= '0;
      run_last_r <= 1'b1;
      text_end_r <= final_r;
      err_r      <= cmd.err_code;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.text_end   = text_end_r;
  assign out_ch.error_code = err_r;

endmodule

// File: hdl/byte_pair_token_expander_unit.sv
// ----------------------------------------------------------------------------
// byte_pair_token_expander_unit
// table write: taken while idle. decode: check and lookup per inner symbol,
// check per low symbol, check and lookup per table leaf during the walk, then
// fetch and load per emitted byte, set by the single-read merge table and run
// buffer; one decode at a time. an error is loaded from the error state.
// reset: synchronous; clears walk control and sets last_symbol to 255,
// merge table and walk stack keep their contents.
// ----------------------------------------------------------------------------
module byte_pair_token_expander_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  bpte_in_if.sink                    in_ch,
  bpte_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [bpte_pkg::SYM_W-1:0] cfg_data
);
  import bpte_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  bpte_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  bpte_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

endmodule
